// ----- rtl/adaptive_channel_hop_scheduler_unit_assert.svh -----
// Assertion macros used by the channel-hop scheduler RTL.
`ifndef ADAPTIVE_CHANNEL_HOP_SCHEDULER_UNIT_ASSERT_SVH
`define ADAPTIVE_CHANNEL_HOP_SCHEDULER_UNIT_ASSERT_SVH

// check a property on every clock edge outside reset
`define ACHS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check an implication on every clock edge outside reset
`define ACHS_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ----- rtl/achs_pkg.sv -----
// Types and codes of the channel-hop scheduler.
package achs_pkg;

   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_HIT     = 1'b1;

   localparam logic [1:0] PHASE_SEARCH = 2'd0;
   localparam logic [1:0] PHASE_DWELL  = 2'd1;
   localparam logic [1:0] PHASE_INTER  = 2'd2;

   localparam logic [1:0] CSR_SEARCH_SWEEPS = 2'd0;
   localparam logic [1:0] CSR_FOCUS_SWEEPS  = 2'd1;
   localparam logic [1:0] CSR_MISS_LIMIT    = 2'd2;

   localparam logic [6:0] SEARCH_SWEEPS_RESET = 7'd3;
   localparam logic [6:0] FOCUS_SWEEPS_RESET  = 7'd120;
   localparam logic [1:0] MISS_LIMIT_RESET    = 2'd3;
   localparam logic [6:0] SWEEP_MAX           = 7'd127;
   localparam logic [1:0] MISS_MAX            = 2'd3;

   typedef struct packed {
      logic       op;
      logic [3:0] hit_channel;
   } req_word_type;

   typedef struct packed {
      logic [3:0] channel;
      logic [1:0] phase;
   } rsp_word_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] chan;
   } pick_type;

endpackage

// ----- rtl/achs_pick.sv -----
// Lowest flagged channel above a given channel.
module achs_pick #(
   parameter int NUM_CHANNELS = 14
) (
   input  logic [NUM_CHANNELS:1] mask,
   input  logic [3:0]            after,
   output achs_pkg::pick_type    pick
);
   import achs_pkg::*;

   always_comb begin
      pick = '0;
      for (int c = NUM_CHANNELS; c >= 1; c--) begin
         if (mask[c] && (4'(c) > after)) begin
            pick.hit  = 1'b1;
            pick.chan = 4'(c);
         end
      end
   end

endmodule

// ----- rtl/adaptive_channel_hop_scheduler_unit.sv -----
// Top level of the channel-hop scheduler: state, sweep control and result register.
//
//   port group | direction | handshake          | word
//   req_       | in        | req_valid/req_stall | op, hit_channel
//   rsp_       | out       | rsp_valid/rsp_stall | channel, phase
//   csr_       | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One word per cycle unless stalled, one result per word, valid in the next cycle.
// All scheduling state updates in the accept cycle; the result register holds the word.
// A word is taken whenever the result register is empty or drains in the same cycle.
// Synchronous reset sets all state but the result word; csr_ready is always high.
module adaptive_channel_hop_scheduler_unit #(
   parameter int NUM_CHANNELS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  achs_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output achs_pkg::rsp_word_type  rsp_word,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [6:0]              csr_wdata
);
   import achs_pkg::*;

   `include "adaptive_channel_hop_scheduler_unit_assert.svh"

   localparam logic [3:0] LAST_CH  = 4'(NUM_CHANNELS);
   localparam logic [3:0] LAST_GRP = 4'(NUM_CHANNELS - 1);

   logic [6:0] search_sweeps_ff;
   logic [6:0] focus_sweeps_ff;
   logic [1:0] miss_limit_ff;

   logic [1:0]                  phase_ff, phase_in;
   logic [3:0]                  cur_ff, cur_in;
   logic [NUM_CHANNELS:1]       rem_ff, rem_in;
   logic [NUM_CHANNELS:1]       seen_ff, seen_in;
   logic [1:0]                  miss_ff [NUM_CHANNELS:1];
   logic [1:0]                  miss_in [NUM_CHANNELS:1];
   logic [6:0]                  sweep_ff, sweep_in;
   logic [3:0]                  grp_ff, grp_in;
   logic [1:0]                  sub_ff, sub_in;
   logic [3:0]                  rot_ff, rot_in;
   logic                        act_ff, act_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_word_type                rsp_word_ff, rsp_word_in;

   logic [NUM_CHANNELS:1]       rem_round, seen_round;
   logic [1:0]                  miss_round [NUM_CHANNELS:1];
   logic [1:0]                  miss_inc;
   pick_type                    pick_cur, pick_first, pick_rot, pick_new;
   logic                        accept, done;
   logic [3:0]                  next_ch, fresh;
   logic [6:0]                  sweep_sat, target;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   achs_pick #(.NUM_CHANNELS(NUM_CHANNELS)) u_pick_cur (
      .mask(rem_ff), .after(cur_ff), .pick(pick_cur));
   achs_pick #(.NUM_CHANNELS(NUM_CHANNELS)) u_pick_first (
      .mask(rem_ff), .after(4'd0), .pick(pick_first));
   achs_pick #(.NUM_CHANNELS(NUM_CHANNELS)) u_pick_rot (
      .mask(rem_ff), .after(rot_ff), .pick(pick_rot));
   achs_pick #(.NUM_CHANNELS(NUM_CHANNELS)) u_pick_new (
      .mask(rem_round), .after(4'd0), .pick(pick_new));

   // end-of-round aging of remembered channels
   always_comb begin
      rem_round  = rem_ff;
      seen_round = seen_ff;
      miss_inc   = '0;
      for (int c = 1; c <= NUM_CHANNELS; c++) begin
         miss_round[c] = miss_ff[c];
         if (rem_ff[c]) begin
            if (seen_ff[c]) begin
               miss_round[c] = '0;
               seen_round[c] = 1'b0;
            end else begin
               miss_inc = (miss_ff[c] == MISS_MAX) ? MISS_MAX : miss_ff[c] + 2'd1;
               if (miss_inc >= miss_limit_ff) begin
                  rem_round[c]  = 1'b0;
                  miss_round[c] = '0;
                  seen_round[c] = 1'b0;
               end else begin
                  miss_round[c] = miss_inc;
               end
            end
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      cur_in    = cur_ff;
      rem_in    = rem_ff;
      seen_in   = seen_ff;
      miss_in   = miss_ff;
      sweep_in  = sweep_ff;
      grp_in    = grp_ff;
      sub_in    = sub_ff;
      rot_in    = rot_ff;
      act_in    = act_ff;
      done      = 1'b0;
      next_ch   = cur_ff;
      fresh     = grp_ff + 4'd1;
      sweep_sat = (sweep_ff == SWEEP_MAX) ? SWEEP_MAX : sweep_ff + 7'd1;
      target    = (phase_ff == PHASE_DWELL) ? focus_sweeps_ff : search_sweeps_ff;

      if (accept && (req_word.op == OP_ADVANCE)) begin
         case (phase_ff)
            PHASE_SEARCH: begin
               if (cur_ff >= LAST_CH) begin
                  next_ch = 4'd1;
                  done    = 1'b1;
               end else begin
                  next_ch = cur_ff + 4'd1;
               end
            end
            PHASE_DWELL: begin
               if (pick_cur.hit) begin
                  next_ch = pick_cur.chan;
               end else begin
                  done    = 1'b1;
                  next_ch = pick_first.hit ? pick_first.chan : 4'd1;
               end
            end
            default: begin
               if (sub_ff == 2'd0) begin
                  next_ch = fresh;
               end else if (pick_rot.hit) begin
                  next_ch = pick_rot.chan;
                  rot_in  = pick_rot.chan;
               end else if (pick_first.hit) begin
                  next_ch = pick_first.chan;
                  rot_in  = pick_first.chan;
               end else begin
                  next_ch = fresh;
               end
               if (sub_ff == 2'd2) begin
                  sub_in = 2'd0;
                  if (grp_ff == LAST_GRP) begin
                     grp_in = '0;
                     done   = 1'b1;
                  end else begin
                     grp_in = grp_ff + 4'd1;
                  end
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         endcase
         cur_in = next_ch;

         if (done) begin
            if (sweep_sat < target) begin
               sweep_in = sweep_sat;
            end else begin
               sweep_in = '0;
               case (phase_ff)
                  PHASE_SEARCH: begin
                     if (pick_first.hit) begin
                        phase_in = PHASE_DWELL;
                        cur_in   = pick_first.chan;
                     end
                  end
                  PHASE_DWELL: begin
                     phase_in = PHASE_INTER;
                     act_in   = 1'b0;
                     cur_in   = 4'd1;
                     grp_in   = '0;
                     sub_in   = 2'd1;
                  end
                  default: begin
                     rem_in  = rem_round;
                     seen_in = seen_round;
                     miss_in = miss_round;
                     if (!(|rem_round) || !act_ff) begin
                        phase_in = PHASE_SEARCH;
                        cur_in   = 4'd1;
                     end else begin
                        phase_in = PHASE_DWELL;
                        cur_in   = pick_new.hit ? pick_new.chan : 4'd1;
                     end
                  end
               endcase
            end
         end
      end else if (accept && (req_word.op == OP_HIT)) begin
         if ((req_word.hit_channel >= 4'd1) && (req_word.hit_channel <= LAST_CH)) begin
            rem_in[req_word.hit_channel]  = 1'b1;
            seen_in[req_word.hit_channel] = 1'b1;
            if (phase_ff == PHASE_INTER) begin
               act_in = 1'b1;
            end
         end
      end

      rsp_word_in.channel = cur_in;
      rsp_word_in.phase   = phase_in;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_sweeps_ff <= SEARCH_SWEEPS_RESET;
         focus_sweeps_ff  <= FOCUS_SWEEPS_RESET;
         miss_limit_ff    <= MISS_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEARCH_SWEEPS: search_sweeps_ff <= csr_wdata;
            CSR_FOCUS_SWEEPS:  focus_sweeps_ff  <= csr_wdata;
            CSR_MISS_LIMIT:    miss_limit_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_SEARCH;
         cur_ff       <= '0;
         rem_ff       <= '0;
         seen_ff      <= '0;
         sweep_ff     <= '0;
         grp_ff       <= '0;
         sub_ff       <= '0;
         rot_ff       <= 4'd1;
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 1; c <= NUM_CHANNELS; c++) begin
            miss_ff[c] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         cur_ff       <= cur_in;
         rem_ff       <= rem_in;
         seen_ff      <= seen_in;
         miss_ff      <= miss_in;
         sweep_ff     <= sweep_in;
         grp_ff       <= grp_in;
         sub_ff       <= sub_in;
         rot_ff       <= rot_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   `ACHS_ASSERT(a_seen_needs_rem, clock, reset, (seen_ff & ~rem_ff) == '0, "seen flag on forgotten channel")
   `ACHS_ASSERT(a_rot_range, clock, reset, (rot_ff >= 4'd1) && (rot_ff <= LAST_CH), "rotation pointer out of range")
   `ACHS_ASSERT_IMPL(a_slot_range, clock, reset, phase_ff == PHASE_INTER, (grp_ff <= LAST_GRP) && (sub_ff != 2'd3), "slot out of range")
   `ACHS_ASSERT_IMPL(a_rsp_channel, clock, reset, rsp_valid_ff, rsp_word_ff.channel <= LAST_CH, "result channel out of range")

endmodule
